>>> src/sm83_pkg.sv
// shared constants for the sm83 instruction subset execute unit
`default_nettype none

package sm83_pkg;

    // register file values after reset
    localparam logic [15:0] RstAf = 16'h01B0;
    localparam logic [15:0] RstBc = 16'h0013;
    localparam logic [15:0] RstDe = 16'h00D8;
    localparam logic [15:0] RstHl = 16'h014D;
    localparam logic [15:0] RstSp = 16'hFFFE;
    localparam logic [15:0] RstPc = 16'h0100;

    // flag bit positions inside F
    localparam int unsigned FlagZ = 7;
    localparam int unsigned FlagN = 6;
    localparam int unsigned FlagH = 5;
    localparam int unsigned FlagC = 4;

    // cycles charged per instruction class
    localparam logic [2:0] CycNone  = 3'd0;
    localparam logic [2:0] CycShort = 3'd2;
    localparam logic [2:0] CycMid   = 3'd3;
    localparam logic [2:0] CycLong  = 3'd4;
    localparam logic [2:0] CycJump  = 3'd5;

    // 8-bit register indexes as encoded in the opcode
    localparam logic [2:0] R8B   = 3'd0;
    localparam logic [2:0] R8C   = 3'd1;
    localparam logic [2:0] R8D   = 3'd2;
    localparam logic [2:0] R8E   = 3'd3;
    localparam logic [2:0] R8H   = 3'd4;
    localparam logic [2:0] R8L   = 3'd5;
    localparam logic [2:0] R8Mem = 3'd6;
    localparam logic [2:0] R8A   = 3'd7;

    // 16-bit pair indexes
    localparam logic [1:0] R16Bc = 2'd0;
    localparam logic [1:0] R16De = 2'd1;
    localparam logic [1:0] R16Hl = 2'd2;
    localparam logic [1:0] R16Sp = 2'd3;

    // opcodes
    localparam logic [7:0] OpNop    = 8'h00;
    localparam logic [7:0] OpLdBcA  = 8'h02;
    localparam logic [7:0] OpJr     = 8'h18;
    localparam logic [7:0] OpJrNz   = 8'h20;
    localparam logic [7:0] OpIncL   = 8'h2C;
    localparam logic [7:0] OpCpl    = 8'h2F;
    localparam logic [7:0] OpLddHlA = 8'h32;
    localparam logic [7:0] OpJp     = 8'hC3;
    localparam logic [7:0] MaskPair = 8'hCF;
    localparam logic [7:0] OpLdRrNn = 8'h01;
    localparam logic [7:0] OpIncRr  = 8'h03;

endpackage

`default_nettype wire

>>> src/sm83_instruction_subset_execute_unit.sv
// execute unit for a subset of an sm83-style 8-bit cpu, one instruction per item
// an item passes the input register, then the result register that drives o_out_*
// throughput: one item per cycle while i_out_ready holds; the input register and
//   the result register move together, and the register file updates in that cycle
// reset (i_rst_n low, synchronous): both stages empty, registers and pc take
//   their power-on values (af 01b0, bc 0013, de 00d8, hl 014d, sp fffe, pc 0100)
`default_nettype none

module sm83_instruction_subset_execute_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // instruction item
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_op,
    input  wire logic [7:0]  i_imm_low,
    input  wire logic [7:0]  i_imm_high,
    input  wire logic [7:0]  i_load_byte,
    // result item
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [15:0]      o_next_pc,
    output logic [15:0]      o_acc_flags,
    output logic [15:0]      o_pair_b_c,
    output logic [15:0]      o_pair_d_e,
    output logic [15:0]      o_pair_h_l,
    output logic [15:0]      o_stack_pointer,
    output logic             o_store_valid,
    output logic [15:0]      o_store_addr,
    output logic [7:0]       o_store_data,
    output logic [2:0]       o_cycle_count,
    output logic             o_undefined_op
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_op, r_lo, r_hi, r_mem;

    // architectural state
    logic [15:0] r_af, r_bc, r_de, r_hl, r_sp, r_pc;
    logic [15:0] n_af, n_bc, n_de, n_hl, n_sp, n_pc;

    // result register
    logic        r_out_valid;
    logic        r_st, r_undef;
    logic [15:0] r_st_addr;
    logic [7:0]  r_st_data;
    logic [2:0]  r_cyc;

    logic        adv;

    // the input stage moves on whenever the result stage is free or being drained
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    // 8-bit register read, index as encoded in the opcode
    function automatic logic [7:0] rd8(input logic [2:0] idx, input logic [15:0] af,
                                       input logic [15:0] bc, input logic [15:0] de,
                                       input logic [15:0] hl);
        logic [7:0] v;
        case (idx)
            sm83_pkg::R8B: v = bc[15:8];
            sm83_pkg::R8C: v = bc[7:0];
            sm83_pkg::R8D: v = de[15:8];
            sm83_pkg::R8E: v = de[7:0];
            sm83_pkg::R8H: v = hl[15:8];
            sm83_pkg::R8L: v = hl[7:0];
            sm83_pkg::R8A: v = af[15:8];
            default:       v = 8'h00;
        endcase
        return v;
    endfunction

    // decode and execute
    logic [2:0]  x, y;
    logic [7:0]  acc, f, src8, dst8, res8;
    logic [7:0]  n_f;
    logic        wr8_en;
    logic [2:0]  wr8_idx;
    logic [7:0]  wr8_val;
    logic        wr16_en;
    logic [1:0]  wr16_idx;
    logic [15:0] wr16_val;
    logic [15:0] pc_rel, pc1, pc2, pc3, pair_rd;
    logic [8:0]  diff;
    logic [4:0]  diff_lo;
    logic        borrow_in;
    logic        c_st, c_undef;
    logic [15:0] c_st_addr;
    logic [7:0]  c_st_data;
    logic [2:0]  c_cyc;

    always_comb begin
        x    = r_op[5:3];
        y    = r_op[2:0];
        acc  = r_af[15:8];
        f    = r_af[7:0];
        src8 = rd8(y, r_af, r_bc, r_de, r_hl);
        dst8 = rd8(x, r_af, r_bc, r_de, r_hl);
        pc1  = r_pc + 16'd1;
        pc2  = r_pc + 16'd2;
        pc3  = r_pc + 16'd3;
        // relative target counts from the byte after the two-byte instruction
        pc_rel = pc2 + {{8{r_lo[7]}}, r_lo};

        case (r_op[5:4])
            sm83_pkg::R16Bc: pair_rd = r_bc;
            sm83_pkg::R16De: pair_rd = r_de;
            sm83_pkg::R16Hl: pair_rd = r_hl;
            default:         pair_rd = r_sp;
        endcase

        // sub / sbc borrow chain, carry in only for sbc
        borrow_in = r_op[3] & f[sm83_pkg::FlagC];
        diff      = {1'b0, acc} - {1'b0, src8} - {8'd0, borrow_in};
        diff_lo   = {1'b0, acc[3:0]} - {1'b0, src8[3:0]} - {4'd0, borrow_in};

        n_f       = f;
        n_pc      = pc1;
        wr8_en    = 1'b0;
        wr8_idx   = sm83_pkg::R8A;
        wr8_val   = 8'h00;
        wr16_en   = 1'b0;
        wr16_idx  = sm83_pkg::R16Bc;
        wr16_val  = 16'h0000;
        res8      = 8'h00;
        c_st      = 1'b0;
        c_st_addr = 16'h0000;
        c_st_data = 8'h00;
        c_cyc     = sm83_pkg::CycNone;
        c_undef   = 1'b0;

        if (r_op == sm83_pkg::OpNop) begin
            c_cyc = sm83_pkg::CycShort;
        end else if ((r_op & sm83_pkg::MaskPair) == sm83_pkg::OpLdRrNn) begin
            wr16_en  = 1'b1;
            wr16_idx = r_op[5:4];
            wr16_val = {r_hi, r_lo};
            n_pc     = pc3;
            c_cyc    = sm83_pkg::CycLong;
        end else if (r_op == sm83_pkg::OpLdBcA) begin
            c_st      = 1'b1;
            c_st_addr = r_bc;
            c_st_data = acc;
            c_cyc     = sm83_pkg::CycMid;
        end else if ((r_op & sm83_pkg::MaskPair) == sm83_pkg::OpIncRr) begin
            wr16_en  = 1'b1;
            wr16_idx = r_op[5:4];
            wr16_val = pair_rd + 16'd1;
            c_cyc    = sm83_pkg::CycMid;
        end else if (!r_op[7] && !r_op[6] && y == 3'd5 && x != sm83_pkg::R8Mem) begin
            // dec r
            res8                 = dst8 - 8'd1;
            n_f[sm83_pkg::FlagN] = 1'b1;
            n_f[sm83_pkg::FlagZ] = (res8 == 8'h00);
            n_f[sm83_pkg::FlagH] = (dst8[3:0] == 4'h0);
            wr8_en               = 1'b1;
            wr8_idx              = x;
            wr8_val              = res8;
            c_cyc                = sm83_pkg::CycShort;
        end else if (!r_op[7] && !r_op[6] && y == 3'd6 && x != sm83_pkg::R8Mem) begin
            // ld r,imm8
            wr8_en  = 1'b1;
            wr8_idx = x;
            wr8_val = r_lo;
            n_pc    = pc2;
            c_cyc   = sm83_pkg::CycMid;
        end else if (r_op == sm83_pkg::OpJr) begin
            n_pc  = pc_rel;
            c_cyc = sm83_pkg::CycLong;
        end else if (r_op == sm83_pkg::OpJrNz) begin
            if (f[sm83_pkg::FlagZ]) begin
                n_pc  = pc2;
                c_cyc = sm83_pkg::CycMid;
            end else begin
                n_pc  = pc_rel;
                c_cyc = sm83_pkg::CycLong;
            end
        end else if (r_op == sm83_pkg::OpIncL) begin
            res8                 = r_hl[7:0] + 8'd1;
            n_f[sm83_pkg::FlagN] = 1'b0;
            n_f[sm83_pkg::FlagZ] = (res8 == 8'h00);
            n_f[sm83_pkg::FlagH] = (r_hl[3:0] == 4'hF);
            wr8_en               = 1'b1;
            wr8_idx              = sm83_pkg::R8L;
            wr8_val              = res8;
            c_cyc                = sm83_pkg::CycShort;
        end else if (r_op == sm83_pkg::OpCpl) begin
            n_f[sm83_pkg::FlagN] = 1'b1;
            n_f[sm83_pkg::FlagH] = 1'b1;
            wr8_en               = 1'b1;
            wr8_idx              = sm83_pkg::R8A;
            wr8_val              = ~acc;
            c_cyc                = sm83_pkg::CycShort;
        end else if (r_op == sm83_pkg::OpLddHlA) begin
            // store at hl before its decrement
            c_st      = 1'b1;
            c_st_addr = r_hl;
            c_st_data = acc;
            wr16_en   = 1'b1;
            wr16_idx  = sm83_pkg::R16Hl;
            wr16_val  = r_hl - 16'd1;
            c_cyc     = sm83_pkg::CycMid;
        end else if ((r_op inside {[8'h40:8'h7F]}) && x != sm83_pkg::R8Mem) begin
            wr8_en  = 1'b1;
            wr8_idx = x;
            if (y == sm83_pkg::R8Mem) begin
                wr8_val = r_mem;
                c_cyc   = sm83_pkg::CycMid;
            end else begin
                wr8_val = src8;
                c_cyc   = sm83_pkg::CycShort;
            end
        end else if ((r_op inside {[8'h90:8'h9F]}) && y != sm83_pkg::R8Mem) begin
            // sub / sbc
            res8                 = diff[7:0];
            n_f[sm83_pkg::FlagN] = 1'b1;
            n_f[sm83_pkg::FlagZ] = (res8 == 8'h00);
            n_f[sm83_pkg::FlagH] = diff_lo[4];
            n_f[sm83_pkg::FlagC] = diff[8];
            wr8_en               = 1'b1;
            wr8_idx              = sm83_pkg::R8A;
            wr8_val              = res8;
            c_cyc                = sm83_pkg::CycShort;
        end else if ((r_op inside {[8'hA8:8'hAF]}) && y != sm83_pkg::R8Mem) begin
            res8                 = acc ^ src8;
            n_f[sm83_pkg::FlagZ] = (res8 == 8'h00);
            n_f[sm83_pkg::FlagN] = 1'b0;
            n_f[sm83_pkg::FlagH] = 1'b0;
            n_f[sm83_pkg::FlagC] = 1'b0;
            wr8_en               = 1'b1;
            wr8_idx              = sm83_pkg::R8A;
            wr8_val              = res8;
            c_cyc                = sm83_pkg::CycShort;
        end else if (r_op == sm83_pkg::OpJp) begin
            n_pc  = {r_hi, r_lo};
            c_cyc = sm83_pkg::CycJump;
        end else begin
            // not in the subset: state and pc stay as they are
            c_undef = 1'b1;
            n_pc    = r_pc;
        end

        // register file write-back, at most one port is active per instruction
        n_af = {r_af[15:8], n_f};
        n_bc = r_bc;
        n_de = r_de;
        n_hl = r_hl;
        n_sp = r_sp;
        if (wr16_en) begin
            case (wr16_idx)
                sm83_pkg::R16Bc: n_bc = wr16_val;
                sm83_pkg::R16De: n_de = wr16_val;
                sm83_pkg::R16Hl: n_hl = wr16_val;
                default:         n_sp = wr16_val;
            endcase
        end
        if (wr8_en) begin
            case (wr8_idx)
                sm83_pkg::R8B: n_bc[15:8] = wr8_val;
                sm83_pkg::R8C: n_bc[7:0]  = wr8_val;
                sm83_pkg::R8D: n_de[15:8] = wr8_val;
                sm83_pkg::R8E: n_de[7:0]  = wr8_val;
                sm83_pkg::R8H: n_hl[15:8] = wr8_val;
                sm83_pkg::R8L: n_hl[7:0]  = wr8_val;
                sm83_pkg::R8A: n_af[15:8] = wr8_val;
                default: begin
                end
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op  <= i_op;
            r_lo  <= i_imm_low;
            r_hi  <= i_imm_high;
            r_mem <= i_load_byte;
        end
    end

    // architectural state, updated as an item moves into the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_af <= sm83_pkg::RstAf;
            r_bc <= sm83_pkg::RstBc;
            r_de <= sm83_pkg::RstDe;
            r_hl <= sm83_pkg::RstHl;
            r_sp <= sm83_pkg::RstSp;
            r_pc <= sm83_pkg::RstPc;
        end else if (adv) begin
            r_af <= n_af;
            r_bc <= n_bc;
            r_de <= n_de;
            r_hl <= n_hl;
            r_sp <= n_sp;
            r_pc <= n_pc;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_st      <= c_st;
            r_st_addr <= c_st_addr;
            r_st_data <= c_st_data;
            r_cyc     <= c_cyc;
            r_undef   <= c_undef;
        end
    end

    // the register outputs reflect the state left by the item in the result stage
    assign o_out_valid     = r_out_valid;
    assign o_next_pc       = r_pc;
    assign o_acc_flags     = r_af;
    assign o_pair_b_c      = r_bc;
    assign o_pair_d_e      = r_de;
    assign o_pair_h_l      = r_hl;
    assign o_stack_pointer = r_sp;
    assign o_store_valid   = r_st;
    assign o_store_addr    = r_st_addr;
    assign o_store_data    = r_st_data;
    assign o_cycle_count   = r_cyc;
    assign o_undefined_op  = r_undef;

endmodule

`default_nettype wire

>>> src/sm83_chk.sv
// port-level checker for the sm83 execute unit, with its bind
`default_nettype none

module sm83_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] o_next_pc,
    input wire logic        o_store_valid,
    input wire logic [2:0]  o_cycle_count,
    input wire logic        o_undefined_op
);

    // an undefined opcode charges nothing and stores nothing
    a_undef_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_undefined_op) |->
        (o_cycle_count == sm83_pkg::CycNone && !o_store_valid))
        else $error("undefined item with cycles or store");

    // a defined instruction charges between CycShort and CycJump
    a_cyc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_undefined_op) |->
        (o_cycle_count >= sm83_pkg::CycShort && o_cycle_count <= sm83_pkg::CycJump))
        else $error("cycle count out of range");

    // both store forms charge CycMid
    a_store_cyc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_store_valid) |->
        (o_cycle_count == sm83_pkg::CycMid && !o_undefined_op))
        else $error("store with wrong cycle count");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_next_pc) && $stable(o_cycle_count)))
        else $error("stalled result changed");

endmodule

bind sm83_instruction_subset_execute_unit sm83_chk u_sm83_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_next_pc      (o_next_pc),
    .o_store_valid  (o_store_valid),
    .o_cycle_count  (o_cycle_count),
    .o_undefined_op (o_undefined_op)
);

`default_nettype wire

>>> sim/tb_top.sv
// testbench for the sm83 instruction subset execute unit with predictor and scoreboard

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // opcode ranges and slots not named in the package
    localparam logic [7:0] OpLdFirst  = 8'h40;  // ld r,r and ld r,(hl)
    localparam logic [7:0] OpLdLast   = 8'h7F;
    localparam logic [7:0] OpHalt     = 8'h76;
    localparam logic [7:0] OpSubFirst = 8'h90;  // sub r, bit 3 selects sbc
    localparam logic [7:0] OpSbcFirst = 8'h98;
    localparam logic [7:0] OpSbcLast  = 8'h9F;
    localparam logic [7:0] OpXorFirst = 8'hA8;
    localparam logic [7:0] OpXorLast  = 8'hAF;
    localparam logic [7:0] OpLastLow  = 8'h3F;  // end of the block with dec r and ld r,imm8
    localparam logic [2:0] SlotDec    = 3'd5;   // low opcode bits of dec r
    localparam logic [2:0] SlotLdImm  = 3'd6;   // low opcode bits of ld r,imm8

    localparam int unsigned RandomItems = 1300;
    localparam int unsigned CycleLimit  = 200000;
    localparam int unsigned DrainCycles = 4;

    // one expected result item
    typedef struct packed {
        logic [15:0] next_pc;
        logic [15:0] acc_flags;
        logic [15:0] pair_b_c;
        logic [15:0] pair_d_e;
        logic [15:0] pair_h_l;
        logic [15:0] stack_pointer;
        logic        store_valid;
        logic [15:0] store_addr;
        logic [7:0]  store_data;
        logic [2:0]  cycle_count;
        logic        undefined_op;
    } t_exec_result;

    // cpu state mirror plus the queue of results still owed by the block
    class t_exec_scoreboard;
        logic [15:0] af, bc, de, hl, sp, pc;
        t_exec_result expected_results[$];
        int unsigned errors;

        function new();
            af = sm83_pkg::RstAf;
            bc = sm83_pkg::RstBc;
            de = sm83_pkg::RstDe;
            hl = sm83_pkg::RstHl;
            sp = sm83_pkg::RstSp;
            pc = sm83_pkg::RstPc;
            errors = 0;
        endfunction

        function logic [7:0] get_r8(logic [2:0] idx);
            case (idx)
                sm83_pkg::R8B: return bc[15:8];
                sm83_pkg::R8C: return bc[7:0];
                sm83_pkg::R8D: return de[15:8];
                sm83_pkg::R8E: return de[7:0];
                sm83_pkg::R8H: return hl[15:8];
                sm83_pkg::R8L: return hl[7:0];
                sm83_pkg::R8A: return af[15:8];
                default: return 8'h00;
            endcase
        endfunction

        function void set_r8(logic [2:0] idx, logic [7:0] v);
            case (idx)
                sm83_pkg::R8B: bc[15:8] = v;
                sm83_pkg::R8C: bc[7:0] = v;
                sm83_pkg::R8D: de[15:8] = v;
                sm83_pkg::R8E: de[7:0] = v;
                sm83_pkg::R8H: hl[15:8] = v;
                sm83_pkg::R8L: hl[7:0] = v;
                sm83_pkg::R8A: af[15:8] = v;
                default: ;
            endcase
        endfunction

        function logic [15:0] get_pair(logic [1:0] idx);
            case (idx)
                sm83_pkg::R16Bc: return bc;
                sm83_pkg::R16De: return de;
                sm83_pkg::R16Hl: return hl;
                default: return sp;
            endcase
        endfunction

        function void set_pair(logic [1:0] idx, logic [15:0] v);
            case (idx)
                sm83_pkg::R16Bc: bc = v;
                sm83_pkg::R16De: de = v;
                sm83_pkg::R16Hl: hl = v;
                default: sp = v;
            endcase
        endfunction

        // execute one accepted instruction and queue the result it must produce
        function void note_instr(logic [7:0] op, logic [7:0] lo, logic [7:0] hi,
                                 logic [7:0] mem);
            t_exec_result res;
            logic [15:0] npc;
            logic [15:0] rel_pc;
            logic [2:0] x, y;
            logic [7:0] old_v, new_v, a_v, b_v;
            logic borrow_in;
            logic [4:0] nib_need;
            logic [8:0] full_need;
            res = '0;
            npc = pc + 16'd1;
            rel_pc = pc + 16'd2 + {{8{lo[7]}}, lo};
            x = op[5:3];
            y = op[2:0];
            if (op == sm83_pkg::OpNop) begin
                res.cycle_count = sm83_pkg::CycShort;
            end else if ((op & sm83_pkg::MaskPair) == sm83_pkg::OpLdRrNn) begin
                set_pair(op[5:4], {hi, lo});
                npc = pc + 16'd3;
                res.cycle_count = sm83_pkg::CycLong;
            end else if (op == sm83_pkg::OpLdBcA) begin
                res.store_valid = 1'b1;
                res.store_addr = bc;
                res.store_data = af[15:8];
                res.cycle_count = sm83_pkg::CycMid;
            end else if ((op & sm83_pkg::MaskPair) == sm83_pkg::OpIncRr) begin
                set_pair(op[5:4], get_pair(op[5:4]) + 16'd1);
                res.cycle_count = sm83_pkg::CycMid;
            end else if (op <= OpLastLow && y == SlotDec && x != sm83_pkg::R8Mem) begin
                old_v = get_r8(x);
                new_v = old_v - 8'd1;
                af[sm83_pkg::FlagN] = 1'b1;
                af[sm83_pkg::FlagZ] = (new_v == 8'h00);
                af[sm83_pkg::FlagH] = (old_v[3:0] == 4'h0);
                set_r8(x, new_v);
                res.cycle_count = sm83_pkg::CycShort;
            end else if (op <= OpLastLow && y == SlotLdImm && x != sm83_pkg::R8Mem) begin
                set_r8(x, lo);
                npc = pc + 16'd2;
                res.cycle_count = sm83_pkg::CycMid;
            end else if (op == sm83_pkg::OpJr) begin
                npc = rel_pc;
                res.cycle_count = sm83_pkg::CycLong;
            end else if (op == sm83_pkg::OpJrNz) begin
                if (af[sm83_pkg::FlagZ]) begin
                    npc = pc + 16'd2;
                    res.cycle_count = sm83_pkg::CycMid;
                end else begin
                    npc = rel_pc;
                    res.cycle_count = sm83_pkg::CycLong;
                end
            end else if (op == sm83_pkg::OpIncL) begin
                old_v = hl[7:0];
                new_v = old_v + 8'd1;
                af[sm83_pkg::FlagN] = 1'b0;
                af[sm83_pkg::FlagZ] = (new_v == 8'h00);
                af[sm83_pkg::FlagH] = (old_v[3:0] == 4'hF);
                hl[7:0] = new_v;
                res.cycle_count = sm83_pkg::CycShort;
            end else if (op == sm83_pkg::OpCpl) begin
                af[15:8] = ~af[15:8];
                af[sm83_pkg::FlagN] = 1'b1;
                af[sm83_pkg::FlagH] = 1'b1;
                res.cycle_count = sm83_pkg::CycShort;
            end else if (op == sm83_pkg::OpLddHlA) begin
                res.store_valid = 1'b1;
                res.store_addr = hl;
                res.store_data = af[15:8];
                hl = hl - 16'd1;
                res.cycle_count = sm83_pkg::CycMid;
            end else if (op >= OpLdFirst && op <= OpLdLast && x != sm83_pkg::R8Mem) begin
                if (y == sm83_pkg::R8Mem) begin
                    set_r8(x, mem);
                    res.cycle_count = sm83_pkg::CycMid;
                end else begin
                    set_r8(x, get_r8(y));
                    res.cycle_count = sm83_pkg::CycShort;
                end
            end else if (op >= OpSubFirst && op <= OpSbcLast && y != sm83_pkg::R8Mem) begin
                a_v = af[15:8];
                b_v = get_r8(y);
                borrow_in = (op >= OpSbcFirst) && af[sm83_pkg::FlagC];
                nib_need = {1'b0, b_v[3:0]} + {4'b0, borrow_in};
                full_need = {1'b0, b_v} + {8'b0, borrow_in};
                new_v = a_v - b_v - {7'b0, borrow_in};
                af[sm83_pkg::FlagN] = 1'b1;
                af[sm83_pkg::FlagZ] = (new_v == 8'h00);
                af[sm83_pkg::FlagH] = ({1'b0, a_v[3:0]} < nib_need);
                af[sm83_pkg::FlagC] = ({1'b0, a_v} < full_need);
                af[15:8] = new_v;
                res.cycle_count = sm83_pkg::CycShort;
            end else if (op >= OpXorFirst && op <= OpXorLast && y != sm83_pkg::R8Mem) begin
                new_v = af[15:8] ^ get_r8(y);
                af[sm83_pkg::FlagZ] = (new_v == 8'h00);
                af[sm83_pkg::FlagN] = 1'b0;
                af[sm83_pkg::FlagH] = 1'b0;
                af[sm83_pkg::FlagC] = 1'b0;
                af[15:8] = new_v;
                res.cycle_count = sm83_pkg::CycShort;
            end else if (op == sm83_pkg::OpJp) begin
                npc = {hi, lo};
                res.cycle_count = sm83_pkg::CycJump;
            end else begin
                res.undefined_op = 1'b1;
                res.cycle_count = sm83_pkg::CycNone;
                npc = pc;
            end
            pc = npc;
            res.next_pc = npc;
            res.acc_flags = af;
            res.pair_b_c = bc;
            res.pair_d_e = de;
            res.pair_h_l = hl;
            res.stack_pointer = sp;
            expected_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %h, actual %h", name, want, got);
                errors++;
            end
        endfunction

        // compare one accepted result with the oldest queued expectation
        function void check_result(t_exec_result got);
            t_exec_result want;
            if (expected_results.size() == 0) begin
                $error("result item with no expectation waiting: next_pc %h", got.next_pc);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("next_pc", want.next_pc, got.next_pc);
            compare_field("acc_flags", want.acc_flags, got.acc_flags);
            compare_field("pair_b_c", want.pair_b_c, got.pair_b_c);
            compare_field("pair_d_e", want.pair_d_e, got.pair_d_e);
            compare_field("pair_h_l", want.pair_h_l, got.pair_h_l);
            compare_field("stack_pointer", want.stack_pointer, got.stack_pointer);
            compare_field("store_valid", 16'(want.store_valid), 16'(got.store_valid));
            compare_field("store_addr", want.store_addr, got.store_addr);
            compare_field("store_data", 16'(want.store_data), 16'(got.store_data));
            compare_field("cycle_count", 16'(want.cycle_count), 16'(got.cycle_count));
            compare_field("undefined_op", 16'(want.undefined_op), 16'(got.undefined_op));
        endfunction
    endclass

    // clock, reset and the signals driven into the block
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic [7:0] in_op = 8'h00;
    logic [7:0] in_imm_low = 8'h00;
    logic [7:0] in_imm_high = 8'h00;
    logic [7:0] in_load_byte = 8'h00;
    logic out_ready = 1'b0;

    // outputs of the block
    logic in_ready;
    logic out_valid;
    logic [15:0] out_next_pc, out_acc_flags, out_pair_b_c, out_pair_d_e, out_pair_h_l;
    logic [15:0] out_stack_pointer, out_store_addr;
    logic out_store_valid, out_undefined_op;
    logic [7:0] out_store_data;
    logic [2:0] out_cycle_count;

    // when set, both sides run back to back with no idle cycles
    logic calm = 1'b0;
    int unsigned cycle_cnt = 0;
    t_exec_scoreboard sb = new();

    always #4 clk = ~clk;

    sm83_instruction_subset_execute_unit i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_op            (in_op),
        .i_imm_low       (in_imm_low),
        .i_imm_high      (in_imm_high),
        .i_load_byte     (in_load_byte),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_next_pc       (out_next_pc),
        .o_acc_flags     (out_acc_flags),
        .o_pair_b_c      (out_pair_b_c),
        .o_pair_d_e      (out_pair_d_e),
        .o_pair_h_l      (out_pair_h_l),
        .o_stack_pointer (out_stack_pointer),
        .o_store_valid   (out_store_valid),
        .o_store_addr    (out_store_addr),
        .o_store_data    (out_store_data),
        .o_cycle_count   (out_cycle_count),
        .o_undefined_op  (out_undefined_op)
    );

    // cycle counter, ends a hung run
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CycleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    // both handshakes sampled at the edge, before any driver update lands
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                sb.note_instr(in_op, in_imm_low, in_imm_high, in_load_byte);
            end
            if (out_valid && out_ready) begin
                sb.check_result('{out_next_pc, out_acc_flags, out_pair_b_c, out_pair_d_e,
                                  out_pair_h_l, out_stack_pointer, out_store_valid,
                                  out_store_addr, out_store_data, out_cycle_count,
                                  out_undefined_op});
            end
        end
    end

    // result side: random stall before each result item, ready held until taken
    initial begin
        int unsigned stall;
        while (!rst_n) @(posedge clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // present one instruction item after a random gap and wait for the handshake;
    // valid stays high straight into the next item when the gap is zero
    task automatic send_instr(logic [7:0] op, logic [7:0] lo, logic [7:0] hi,
                              logic [7:0] mem);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_op <= op;
        in_imm_low <= lo;
        in_imm_high <= hi;
        in_load_byte <= mem;
        do @(posedge clk); while (!in_ready);
    endtask

    // any register index except the (hl) slot
    function automatic logic [2:0] pick_r8();
        logic [2:0] idx;
        idx = 3'($urandom_range(0, 6));
        if (idx == sm83_pkg::R8Mem) idx = sm83_pkg::R8A;
        return idx;
    endfunction

    // mostly well-formed subset opcodes, a quarter raw bytes as noise
    function automatic logic [7:0] pick_op();
        case ($urandom_range(0, 19))
            0:  return sm83_pkg::OpNop;
            1:  return sm83_pkg::OpLdRrNn | {2'b00, 2'($urandom_range(0, 3)), 4'h0};
            2:  return sm83_pkg::OpLdBcA;
            3:  return sm83_pkg::OpIncRr | {2'b00, 2'($urandom_range(0, 3)), 4'h0};
            4:  return {2'b00, pick_r8(), SlotDec};
            5:  return {2'b00, pick_r8(), SlotLdImm};
            6:  return sm83_pkg::OpJr;
            7:  return sm83_pkg::OpJrNz;
            8:  return sm83_pkg::OpIncL;
            9:  return sm83_pkg::OpCpl;
            10: return sm83_pkg::OpLddHlA;
            11: return {OpLdFirst[7:6], pick_r8(), 3'($urandom_range(0, 7))};
            12: return {OpSubFirst[7:4], 1'($urandom_range(0, 1)), pick_r8()};
            13: return {OpXorFirst[7:3], pick_r8()};
            14: return sm83_pkg::OpJp;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: wraps, flag corners, both jr nz outcomes, undefined forms
        send_instr(sm83_pkg::OpNop, 8'h00, 8'h00, 8'h00);
        send_instr(sm83_pkg::OpLdRrNn | {2'b00, sm83_pkg::R16Sp, 4'h0}, 8'hFF, 8'hFF, 8'h00);
        // sp wraps to 0
        send_instr(sm83_pkg::OpIncRr | {2'b00, sm83_pkg::R16Sp, 4'h0}, 8'h00, 8'h00, 8'h00);
        send_instr(sm83_pkg::OpLdRrNn | {2'b00, sm83_pkg::R16Hl, 4'h0}, 8'h00, 8'h00, 8'h00);
        send_instr(sm83_pkg::OpLddHlA, 8'h00, 8'h00, 8'h00);              // hl wraps down
        send_instr(sm83_pkg::OpLdRrNn | {2'b00, sm83_pkg::R16Bc, 4'h0}, 8'h01, 8'h80, 8'h00);
        send_instr(sm83_pkg::OpLdBcA, 8'h00, 8'h00, 8'h00);
        send_instr({2'b00, sm83_pkg::R8L, SlotLdImm}, 8'hFF, 8'h00, 8'h00);
        send_instr(sm83_pkg::OpIncL, 8'h00, 8'h00, 8'h00);                // ff to 00, z and h
        // 80 to 7f, nibble borrow
        send_instr({2'b00, sm83_pkg::R8B, SlotDec}, 8'h00, 8'h00, 8'h00);
        send_instr({2'b00, sm83_pkg::R8A, SlotLdImm}, 8'h00, 8'h00, 8'h00);
        send_instr({OpSubFirst[7:3], sm83_pkg::R8B}, 8'h00, 8'h00, 8'h00); // full borrow
        send_instr({OpSbcFirst[7:3], sm83_pkg::R8C}, 8'h00, 8'h00, 8'h00); // borrow in used
        send_instr({OpXorFirst[7:3], sm83_pkg::R8A}, 8'h00, 8'h00, 8'h00); // zero result
        send_instr(sm83_pkg::OpJrNz, 8'h10, 8'h00, 8'h00);                // z set, falls through
        send_instr(sm83_pkg::OpCpl, 8'h00, 8'h00, 8'h00);
        send_instr({OpLdFirst[7:6], sm83_pkg::R8D, sm83_pkg::R8Mem}, 8'h00, 8'h00, 8'hFF);
        send_instr({OpLdFirst[7:6], sm83_pkg::R8E, sm83_pkg::R8Mem}, 8'h00, 8'h00, 8'h00);
        send_instr({OpLdFirst[7:6], sm83_pkg::R8A, sm83_pkg::R8D}, 8'h00, 8'h00, 8'h00);
        send_instr({2'b00, sm83_pkg::R8E, SlotDec}, 8'h00, 8'h00, 8'h00);  // clears z
        send_instr(sm83_pkg::OpJrNz, 8'h80, 8'h00, 8'h00);                // taken, most negative
        send_instr(sm83_pkg::OpJp, 8'hFF, 8'hFF, 8'h00);
        send_instr(sm83_pkg::OpJr, 8'h7F, 8'h00, 8'h00);                  // pc wraps past ffff
        send_instr(OpHalt, 8'hFF, 8'hFF, 8'hFF);
        // ld (hl),r is undefined
        send_instr({OpLdFirst[7:6], sm83_pkg::R8Mem, sm83_pkg::R8B}, 8'h00, 8'h00, 8'h00);
        // sub (hl) is undefined
        send_instr({OpSubFirst[7:3], sm83_pkg::R8Mem}, 8'h00, 8'h00, 8'h00);
        send_instr(8'hFF, 8'h00, 8'h00, 8'h00);

        // random part, with stretches where neither side idles
        for (int i = 0; i < RandomItems; i++) begin
            if (i % 100 == 0) calm = ($urandom_range(0, 3) == 0);
            send_instr(pick_op(), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
        end
        in_valid <= 1'b0;

        // drain, then a few spare cycles for anything stray
        while (sb.expected_results.size() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
